// ===== hdl/fwpvd_pkg.sv =====
// Shared types and constants of the four-wheel PI velocity drive.
package fwpvd_pkg;

  localparam int WORD_W        = 32;
  localparam int WHEEL_COUNT   = 4;
  localparam int GAIN_W        = 16;
  localparam int PULSE_W       = 11;
  localparam int COMMAND_LIMIT = 120;
  localparam int PULSE_NEUTRAL = 1500;
  localparam int PULSE_SPAN    = 500;
  localparam int PULSE_MIN     = 1000;
  localparam int PULSE_MAX     = 2000;

  localparam logic [GAIN_W-1:0] KP_RESET = 16'd5120;
  localparam logic [GAIN_W-1:0] KI_RESET = 16'd0;

  // gain times error: 17-bit signed gain by 32-bit signed value
  localparam int PROD_W = GAIN_W + 1 + WORD_W;
  localparam int QUO_W  = PROD_W - 8;
  localparam int SUM_W  = QUO_W + 2;

  // clamped command magnitude and pulse offset
  localparam int CMD_W   = $clog2(COMMAND_LIMIT + 1);
  localparam int X_W     = $clog2(COMMAND_LIMIT * PULSE_SPAN + 1);
  localparam int OFF_W   = $clog2(PULSE_SPAN + 1);
  localparam int RECIP_W = 33;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / COMMAND_LIMIT);

  localparam int IN_DATA_W  = 6 * WORD_W;
  localparam int OUT_DATA_W = ((WHEEL_COUNT * PULSE_W + 2 * WORD_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_KP = 1'b0;
  localparam logic REG_KI = 1'b1;

  typedef struct packed {
    logic en;       // whole pipeline advances
    logic tick1;    // control tick in the input stage
    logic report1;  // report request in the input stage
    logic tick4;    // control tick in the last stage
  } fwpvd_ctl_t;

endpackage

// ===== hdl/four_wheel_pi_velocity_drive.sv =====
// Top level of the four-wheel PI velocity drive.
//
//  channel  | ports      | contents
//  ---------+------------+-------------------------------------------------
//  input    | in_t*      | tick or report request, targets, four positions
//  result   | out_t*     | four ESC pulses, left and right report deltas
//  config   | cfg_p*     | gain registers, APB-style
//
// One request per cycle unless the pipeline holds; each result passes through the stages below in order.
// Pipeline: input register, error/integrator, gain products, clamp, pulse.
// Synchronous active-low reset clears baselines, integrators, pulses, valids.
// The whole pipeline holds while a result waits and out_tready is low.
module four_wheel_pi_velocity_drive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // func
  input  logic                                  in_tuser,
  // target_left, target_right, position_front_left, position_rear_left,
  // position_front_right, position_rear_right
  input  logic [fwpvd_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // pulse_front_left, pulse_rear_left, pulse_front_right, pulse_rear_right,
  // delta_left, delta_right, zero pad
  output logic [fwpvd_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [fwpvd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import fwpvd_pkg::*;

  localparam int LANE_W = WHEEL_COUNT * PULSE_W;

  logic [GAIN_W-1:0] kp_r, ki_r;
  logic cfg_write;

  logic v1_r, f1_r, v2_r, f2_r, v3_r, f3_r, v4_r, f4_r;
  logic [WORD_W-1:0] tl1_r, tr1_r;
  logic [WHEEL_COUNT-1:0][WORD_W-1:0] pos1_r;

  fwpvd_ctl_t ctl;
  logic [WHEEL_COUNT-1:0][PULSE_W-1:0] pulse;
  logic [WORD_W-1:0] delta_left, delta_right;

  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= KP_RESET;
      ki_r <= KI_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[2])
        REG_KP:  kp_r <= cfg_pwdata[GAIN_W-1:0];
        REG_KI:  ki_r <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_KP:  cfg_prdata = {16'd0, kp_r};
      REG_KI:  cfg_prdata = {16'd0, ki_r};
      default: cfg_prdata = '0;
    endcase
  end

  // pipeline control
  assign ctl.en      = !out_valid_r || out_tready;
  assign ctl.tick1   = v1_r && !f1_r;
  assign ctl.report1 = v1_r && f1_r;
  assign ctl.tick4   = v4_r && !f4_r;
  assign in_tready   = ctl.en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ctl.en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      f1_r  <= in_tuser;
      tl1_r <= in_tdata[WORD_W-1:0];
      tr1_r <= in_tdata[2*WORD_W-1:WORD_W];
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        pos1_r[i] <= in_tdata[(i+2)*WORD_W +: WORD_W];
      end
      f2_r <= f1_r;
      f3_r <= f2_r;
      f4_r <= f3_r;
      out_data_r <= {(OUT_DATA_W - LANE_W - 2*WORD_W)'(0), delta_right, delta_left,
                     pulse[3], pulse[2], pulse[1], pulse[0]};
    end
  end

  for (genvar i = 0; i < WHEEL_COUNT; i++) begin : g_wheel
    fwpvd_wheel u_wheel (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .kp       (kp_r),
      .ki       (ki_r),
      .target   ((i < WHEEL_COUNT/2) ? tl1_r : tr1_r),
      .position (pos1_r[i]),
      .pulse    (pulse[i])
    );
  end

  fwpvd_report u_report (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .position    (pos1_r),
    .delta_left  (delta_left),
    .delta_right (delta_right)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/fwpvd_wheel.sv =====
// One wheel lane: error, integrator, PI products, clamp and pulse mapping.
module fwpvd_wheel (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fwpvd_pkg::fwpvd_ctl_t              ctl,
  input  logic [fwpvd_pkg::GAIN_W-1:0]       kp,
  input  logic [fwpvd_pkg::GAIN_W-1:0]       ki,
  input  logic [fwpvd_pkg::WORD_W-1:0]       target,
  input  logic [fwpvd_pkg::WORD_W-1:0]       position,
  output logic [fwpvd_pkg::PULSE_W-1:0]      pulse
);
  import fwpvd_pkg::*;

  localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(COMMAND_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_NEG = -SUM_W'(COMMAND_LIMIT);

  logic [WORD_W-1:0] base_r, integ_r;
  logic [WORD_W-1:0] delta, err, integ_nxt;

  logic [WORD_W-1:0] err2_r, integ2_r, tgt2_r;
  logic signed [PROD_W-1:0] pk3_r, pi3_r;
  logic [WORD_W-1:0] tgt3_r;
  logic neg4_r;
  logic [CMD_W-1:0] mag4_r;
  logic [PULSE_W-1:0] last_pulse_r;

  logic signed [PROD_W-1:0] pk_adj, pi_adj;
  logic signed [QUO_W-1:0]  qk, qi;
  logic signed [SUM_W-1:0]  cmd, cmd_abs;
  logic neg_nxt;
  logic [CMD_W-1:0] mag_nxt;

  logic [X_W-1:0]           x;
  logic [X_W+RECIP_W-1:0]   xr;
  logic [X_W-1:0]           q0;
  logic [X_W+CMD_W-1:0]     q0l;
  logic [X_W-1:0]           rem;
  logic [X_W-1:0]           quo;
  logic [OFF_W-1:0]         off;
  logic [PULSE_W-1:0]       pulse_calc;

  // error and integrator
  assign delta     = position - base_r;
  assign err       = target - delta;
  assign integ_nxt = integ_r + err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      integ_r <= '0;
    end else if (ctl.en && ctl.tick1) begin
      base_r  <= position;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      err2_r   <= err;
      integ2_r <= integ_nxt;
      tgt2_r   <= target;
      pk3_r    <= PROD_W'($signed({1'b0, kp})) * PROD_W'($signed(err2_r));
      pi3_r    <= PROD_W'($signed({1'b0, ki})) * PROD_W'($signed(integ2_r));
      tgt3_r   <= tgt2_r;
      neg4_r   <= neg_nxt;
      mag4_r   <= mag_nxt;
    end
  end

  // truncate products toward zero, sum and clamp
  assign pk_adj = pk3_r + (pk3_r[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign pi_adj = pi3_r + (pi3_r[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign qk     = pk_adj[PROD_W-1:8];
  assign qi     = pi_adj[PROD_W-1:8];
  assign cmd    = SUM_W'($signed(tgt3_r)) + SUM_W'(qk) + SUM_W'(qi);
  assign cmd_abs = cmd[SUM_W-1] ? -cmd : cmd;

  always_comb begin
    if (cmd > LIM_POS) begin
      neg_nxt = 1'b0;
      mag_nxt = CMD_W'(COMMAND_LIMIT);
    end else if (cmd < LIM_NEG) begin
      neg_nxt = 1'b1;
      mag_nxt = CMD_W'(COMMAND_LIMIT);
    end else begin
      neg_nxt = cmd[SUM_W-1];
      mag_nxt = cmd_abs[CMD_W-1:0];
    end
  end

  // offset = mag * span / limit by reciprocal with one correction
  assign x   = X_W'(mag4_r) * X_W'(PULSE_SPAN);
  assign xr  = (X_W+RECIP_W)'(x) * (X_W+RECIP_W)'(RECIP);
  assign q0  = xr[X_W+31:32];
  assign q0l = (X_W+CMD_W)'(q0) * (X_W+CMD_W)'(COMMAND_LIMIT);
  assign rem = x - q0l[X_W-1:0];
  assign quo = (rem >= X_W'(COMMAND_LIMIT)) ? q0 + X_W'(1) : q0;
  assign off = quo[OFF_W-1:0];
  assign pulse_calc = neg4_r ? PULSE_W'(PULSE_NEUTRAL) - PULSE_W'(off)
                             : PULSE_W'(PULSE_NEUTRAL) + PULSE_W'(off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pulse_r <= PULSE_W'(PULSE_NEUTRAL);
    end else if (ctl.en && ctl.tick4) begin
      last_pulse_r <= pulse_calc;
    end
  end

  assign pulse = ctl.tick4 ? pulse_calc : last_pulse_r;

endmodule

// ===== hdl/fwpvd_report.sv =====
// Report baselines and side-averaged count changes.
module fwpvd_report (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  fwpvd_pkg::fwpvd_ctl_t                             ctl,
  input  logic [fwpvd_pkg::WHEEL_COUNT-1:0][fwpvd_pkg::WORD_W-1:0] position,
  output logic [fwpvd_pkg::WORD_W-1:0]                      delta_left,
  output logic [fwpvd_pkg::WORD_W-1:0]                      delta_right
);
  import fwpvd_pkg::*;

  logic [WHEEL_COUNT-1:0][WORD_W-1:0] base_r;
  logic [WHEEL_COUNT-1:0][WORD_W-1:0] d;
  logic signed [WORD_W:0] sum_l, sum_r, half_l, half_r;
  logic [WORD_W-1:0] dl, dr;
  logic [WORD_W-1:0] dl2_r, dr2_r, dl3_r, dr3_r, dl4_r, dr4_r;

  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      d[i] = position[i] - base_r[i];
    end
  end

  assign sum_l  = (WORD_W+1)'($signed(d[0])) + (WORD_W+1)'($signed(d[1]));
  assign sum_r  = (WORD_W+1)'($signed(d[2])) + (WORD_W+1)'($signed(d[3]));
  assign half_l = (sum_l + (WORD_W+1)'(sum_l[WORD_W])) >>> 1;
  assign half_r = (sum_r + (WORD_W+1)'(sum_r[WORD_W])) >>> 1;
  assign dl     = ctl.report1 ? half_l[WORD_W-1:0] : '0;
  assign dr     = ctl.report1 ? half_r[WORD_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (ctl.en && ctl.report1) begin
      base_r <= position;
    end
  end

  // carry the averages alongside the wheel lanes
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dl2_r <= dl;
      dr2_r <= dr;
      dl3_r <= dl2_r;
      dr3_r <= dr2_r;
      dl4_r <= dl3_r;
      dr4_r <= dr3_r;
    end
  end

  assign delta_left  = dl4_r;
  assign delta_right = dr4_r;

endmodule

// ===== hdl/fwpvd_chk.sv =====
// Port-level assertions for the four-wheel PI velocity drive, with bind.
module fwpvd_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [fwpvd_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import fwpvd_pkg::*;

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not track output slot");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[10:0]  >= PULSE_MIN && out_tdata[10:0]  <= PULSE_MAX &&
      out_tdata[21:11] >= PULSE_MIN && out_tdata[21:11] <= PULSE_MAX &&
      out_tdata[32:22] >= PULSE_MIN && out_tdata[32:22] <= PULSE_MAX &&
      out_tdata[43:33] >= PULSE_MIN && out_tdata[43:33] <= PULSE_MAX)
    else $error("pulse out of range");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind four_wheel_pi_velocity_drive fwpvd_chk u_fwpvd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
